>>> design/cfst_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfst_pkg
// Shared types, constants and the quarter-wave sine table of the cycloid
// foot swing trajectory pipeline.
// ----------------------------------------------------------------------------
package cfst_pkg;

    // number formats
    localparam int PHASE_FRAC_BITS  = 16;
    localparam int PHASE_W          = PHASE_FRAC_BITS + 1;
    localparam int POS_BITS         = 24;
    localparam int LIFT_BITS        = 20;
    localparam int DIFF_W           = POS_BITS + 1;
    localparam int SUM_W            = POS_BITS + 4;
    localparam int CYC_W            = PHASE_W + 2;

    // sine table, power-of-two depth
    localparam int SINE_TABLE_DEPTH = 256;
    localparam int SINE_IDX_W       = $clog2(SINE_TABLE_DEPTH);
    localparam int SINE_K_W         = SINE_IDX_W + 2;
    localparam int QSINE_W          = 17;
    localparam int SINE_W           = QSINE_W + 1;

    // fixed-point constants
    localparam longint PI_HALF_Q30  = 64'd1686629713;
    localparam longint INV_2PI_Q32  = 64'd683565276;
    localparam int     INV_W        = 31;
    localparam int     CYC_SHIFT    = 48 - PHASE_FRAC_BITS;

    localparam logic [PHASE_W-1:0] PHASE_ONE  = {1'b1, {PHASE_FRAC_BITS{1'b0}}};
    localparam logic [PHASE_W-1:0] PHASE_HALF = {2'b01, {(PHASE_FRAC_BITS-1){1'b0}}};

    // pipeline depth, stage 0 is the input register, the last is the output register
    localparam int NSTAGE    = 6;

    // configuration register map
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = POS_BITS;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_START_X     = 3'd0,
        REG_START_Y     = 3'd1,
        REG_START_Z     = 3'd2,
        REG_END_X       = 3'd3,
        REG_END_Y       = 3'd4,
        REG_END_Z       = 3'd5,
        REG_LIFT_HEIGHT = 3'd6
    } t_cfg_reg;

    typedef struct packed {
        logic signed [POS_BITS-1:0] start_x;
        logic signed [POS_BITS-1:0] start_y;
        logic signed [POS_BITS-1:0] start_z;
        logic signed [POS_BITS-1:0] end_x;
        logic signed [POS_BITS-1:0] end_y;
        logic signed [POS_BITS-1:0] end_z;
        logic        [LIFT_BITS-1:0] lift_height;
    } t_cfg;

    // stage 0 result: clamped phase, half-swing parameter and sine angle index
    typedef struct packed {
        logic [PHASE_W-1:0]  p;
        logic [PHASE_W-1:0]  u;
        logic                first;
        logic [SINE_K_W-1:0] k;
    } t_front;

    // cycloid term leaving the sine path
    typedef struct packed {
        logic signed [CYC_W-1:0] cyc;
        logic [PHASE_W-1:0]      u;
        logic                    first;
    } t_cyc;

    typedef logic [QSINE_W-1:0] t_qsine [SINE_TABLE_DEPTH];

    // sin(pi/2 * idx/D) in Q16 from a nine-term Taylor series in Q30
    function automatic logic [QSINE_W-1:0] qsine_entry(input int unsigned idx);
        logic [63:0]        x;
        logic [63:0]        x2;
        logic [63:0]        term;
        logic signed [63:0] sum;
        logic signed [63:0] v;
        int                 k;
        x    = (64'(PI_HALF_Q30) * 64'(idx)) / 64'(SINE_TABLE_DEPTH);
        x2   = (x * x) >> 30;
        term = x;
        sum  = $signed(x);
        for (k = 1; k <= 8; k++) begin
            term = ((term * x2) >> 30) / 64'((2 * k) * (2 * k + 1));
            if (k[0]) begin
                sum = sum - $signed(term);
            end else begin
                sum = sum + $signed(term);
            end
        end
        v = (sum + 64'sd8192) >>> 14;
        if (v < 0) begin
            v = 0;
        end
        if (v > 64'sd65536) begin
            v = 64'sd65536;
        end
        return v[QSINE_W-1:0];
    endfunction

    function automatic t_qsine build_qsine();
        t_qsine t;
        for (int i = 0; i < SINE_TABLE_DEPTH; i++) begin
            t[i] = qsine_entry(i);
        end
        return t;
    endfunction

    localparam t_qsine               QSINE     = build_qsine();
    localparam logic [QSINE_W-1:0]   QSINE_TOP = qsine_entry(SINE_TABLE_DEPTH);

    // clamp to the signed position range
    function automatic logic [POS_BITS-1:0] sat_pos(input logic signed [SUM_W-1:0] v);
        logic signed [SUM_W-1:0] hi;
        logic signed [SUM_W-1:0] lo;
        logic signed [SUM_W-1:0] r;
        hi = SUM_W'($signed({1'b0, {(POS_BITS-1){1'b1}}}));
        lo = SUM_W'($signed({1'b1, {(POS_BITS-1){1'b0}}}));
        r  = v;
        if (v > hi) begin
            r = hi;
        end else if (v < lo) begin
            r = lo;
        end
        return r[POS_BITS-1:0];
    endfunction

endpackage

>>> design/cycloid_foot_swing_trajectory.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cycloid_foot_swing_trajectory
// Maps a swing phase to a foot position: linear X/Y, two-half cycloid Z.
// ----------------------------------------------------------------------------
// channel   dir  handshake                         payload
// s_axis    in   i_s_axis_tvalid/o_s_axis_tready   phase [16:0]
// m_axis    out  o_m_axis_tvalid/i_m_axis_tready   pos_x [23:0], pos_y [47:24],
//                                                  pos_z [71:48]
// cfg       in   i_cfg_valid/o_cfg_ready           i_cfg_index, i_cfg_data
//
// six register stages; stage 0 registers the input, the last stage drives the output
// one transaction per cycle without stalls; the multipliers set the stage split
// each stage holds its item until the next stage frees, so bubbles close up
// i_rst_n (synchronous) empties the pipeline and clears the configuration registers
// configuration is always ready and must be written while the pipeline is empty
// ----------------------------------------------------------------------------
module cycloid_foot_swing_trajectory (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // phase [16:0], zero fill [23:17]
    input  logic [23:0]                        i_s_axis_tdata,
    input  logic                               i_s_axis_tvalid,
    output logic                               o_s_axis_tready,
    // pos_x [23:0], pos_y [47:24], pos_z [71:48]
    output logic [3*cfst_pkg::POS_BITS-1:0]    o_m_axis_tdata,
    output logic                               o_m_axis_tvalid,
    input  logic                               i_m_axis_tready,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [cfst_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [cfst_pkg::CFG_DAT_W-1:0]     i_cfg_data
);
    import cfst_pkg::*;

    t_cfg                r_cfg;
    logic [NSTAGE-1:0]   r_vld;
    logic [NSTAGE-1:0]   w_adv;
    t_front              w_front;
    t_cyc                w_cyc;
    logic [POS_BITS-1:0] w_pos_x;
    logic [POS_BITS-1:0] w_pos_y;
    logic [POS_BITS-1:0] w_pos_z;

    // configuration register file, ignores indexes past the map
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_START_X:     r_cfg.start_x     <= i_cfg_data;
                REG_START_Y:     r_cfg.start_y     <= i_cfg_data;
                REG_START_Z:     r_cfg.start_z     <= i_cfg_data;
                REG_END_X:       r_cfg.end_x       <= i_cfg_data;
                REG_END_Y:       r_cfg.end_y       <= i_cfg_data;
                REG_END_Z:       r_cfg.end_z       <= i_cfg_data;
                REG_LIFT_HEIGHT: r_cfg.lift_height <= i_cfg_data[LIFT_BITS-1:0];
                default: begin
                end
            endcase
        end
    end

    assign o_cfg_ready = 1'b1;

    // a stage may load when it is empty or its content moves on
    always_comb begin
        w_adv[NSTAGE-1] = !r_vld[NSTAGE-1] || i_m_axis_tready;
        for (int i = NSTAGE - 2; i >= 0; i--) begin
            w_adv[i] = !r_vld[i] || w_adv[i+1];
        end
    end

    // valid bits travel with the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_adv[0]) begin
                r_vld[0] <= i_s_axis_tvalid;
            end
            for (int i = 1; i < NSTAGE; i++) begin
                if (w_adv[i]) begin
                    r_vld[i] <= r_vld[i-1];
                end
            end
        end
    end

    assign o_s_axis_tready = w_adv[0];
    assign o_m_axis_tvalid = r_vld[NSTAGE-1];

    // stage 0
    cfst_front u_front (
        .i_clk   (i_clk),
        .i_en    (w_adv[0]),
        .i_phase (i_s_axis_tdata[PHASE_W-1:0]),
        .o_front (w_front)
    );

    // stages 1..3, sine and cycloid term
    cfst_sine u_sine (
        .i_clk   (i_clk),
        .i_en    (w_adv[3:1]),
        .i_front (w_front),
        .o_cyc   (w_cyc)
    );

    // stages 1..5, X and Y
    cfst_lerp u_lerp (
        .i_clk   (i_clk),
        .i_en    (w_adv[NSTAGE-1:1]),
        .i_cfg   (r_cfg),
        .i_p     (w_front.p),
        .o_pos_x (w_pos_x),
        .o_pos_y (w_pos_y)
    );

    // stages 4..5, Z
    cfst_z u_z (
        .i_clk   (i_clk),
        .i_en    (w_adv[5:4]),
        .i_cfg   (r_cfg),
        .i_cyc   (w_cyc),
        .o_pos_z (w_pos_z)
    );

    assign o_m_axis_tdata = {w_pos_z, w_pos_y, w_pos_x};

endmodule

>>> design/cfst_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfst_front
// Stage 0: phase clamp, half selection and full-wave sine index.
// ----------------------------------------------------------------------------
module cfst_front (
    input  logic                          i_clk,
    input  logic                          i_en,
    input  logic [cfst_pkg::PHASE_W-1:0]  i_phase,
    output cfst_pkg::t_front              o_front
);
    import cfst_pkg::*;

    localparam int KF_W = PHASE_W + SINE_K_W + 1;

    logic [PHASE_W-1:0] w_p;
    logic [PHASE_W:0]   w_p2;
    logic [KF_W-1:0]    w_kfull;
    t_front             n_front;
    t_front             r_front;

    always_comb begin
        w_p           = (i_phase > PHASE_ONE) ? PHASE_ONE : i_phase;
        w_p2          = {w_p, 1'b0};
        n_front.p     = w_p;
        n_front.first = (w_p < PHASE_HALF);
        // exact midpoint falls into the second half with u = 0
        n_front.u     = n_front.first ? w_p2[PHASE_W-1:0]
                                      : PHASE_W'(w_p2 - {1'b0, PHASE_ONE});
        // round(u * 4D / ONE) mod 4D
        w_kfull       = (KF_W'(n_front.u) << SINE_K_W)
                      + (KF_W'(1) << (PHASE_FRAC_BITS - 1));
        n_front.k     = w_kfull[PHASE_FRAC_BITS +: SINE_K_W];
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_front <= n_front;
        end
    end

    assign o_front = r_front;

endmodule

>>> design/cfst_sine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfst_sine
// Stages 1 to 3: quarter-wave lookup, scale by 1/(2*pi), cycloid term.
// ----------------------------------------------------------------------------
module cfst_sine (
    input  logic              i_clk,
    input  logic [2:0]        i_en,
    input  cfst_pkg::t_front  i_front,
    output cfst_pkg::t_cyc    o_cyc
);
    import cfst_pkg::*;

    localparam int PROD_W = SINE_W + INV_W + 1;
    localparam logic signed [INV_W:0]    INV_C    = (INV_W + 1)'(INV_2PI_Q32);
    localparam logic signed [PROD_W-1:0] CYC_HALF = PROD_W'(1) << (CYC_SHIFT - 1);

    logic [1:0]               w_quad;
    logic [SINE_IDX_W-1:0]    w_r;
    logic [SINE_IDX_W-1:0]    w_ridx;
    logic [QSINE_W-1:0]       w_mag;
    logic signed [SINE_W-1:0] w_sine;
    logic signed [PROD_W-1:0] w_rs;

    logic signed [SINE_W-1:0] r_sine;
    logic [PHASE_W-1:0]       r_u1;
    logic                     r_first1;
    logic signed [PROD_W-1:0] r_prod;
    logic [PHASE_W-1:0]       r_u2;
    logic                     r_first2;
    t_cyc                     n_cyc;
    t_cyc                     r_cyc;

    // stage 1: quadrant fold of the table
    always_comb begin
        w_quad = i_front.k[SINE_K_W-1 -: 2];
        w_r    = i_front.k[SINE_IDX_W-1:0];
        w_ridx = w_quad[0] ? (SINE_IDX_W'(0) - w_r) : w_r;
        if (w_quad[0] && (w_r == '0)) begin
            w_mag = QSINE_TOP;
        end else begin
            w_mag = QSINE[w_ridx];
        end
        w_sine = w_quad[1] ? -$signed({1'b0, w_mag}) : $signed({1'b0, w_mag});
    end

    // stage 3: u - round(s / (2*pi))
    always_comb begin
        w_rs        = (r_prod + CYC_HALF) >>> CYC_SHIFT;
        n_cyc.cyc   = $signed({2'b00, r_u2}) - CYC_W'(w_rs);
        n_cyc.u     = r_u2;
        n_cyc.first = r_first2;
    end

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_sine   <= w_sine;
            r_u1     <= i_front.u;
            r_first1 <= i_front.first;
        end
        if (i_en[1]) begin
            r_prod   <= r_sine * INV_C;
            r_u2     <= r_u1;
            r_first2 <= r_first1;
        end
        if (i_en[2]) begin
            r_cyc    <= n_cyc;
        end
    end

    assign o_cyc = r_cyc;

endmodule

>>> design/cfst_lerp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfst_lerp
// Stages 1 to 5: linear X and Y interpolation, delayed to the output stage.
// ----------------------------------------------------------------------------
module cfst_lerp (
    input  logic                               i_clk,
    input  logic [cfst_pkg::NSTAGE-2:0]        i_en,
    input  cfst_pkg::t_cfg                     i_cfg,
    input  logic [cfst_pkg::PHASE_W-1:0]       i_p,
    output logic [cfst_pkg::POS_BITS-1:0]      o_pos_x,
    output logic [cfst_pkg::POS_BITS-1:0]      o_pos_y
);
    import cfst_pkg::*;

    localparam int MUL_W = DIFF_W + PHASE_W + 1;
    localparam logic signed [MUL_W-1:0] RND_HALF = MUL_W'(1) << (PHASE_FRAC_BITS - 1);

    logic signed [POS_BITS-1:0] w_start [2];
    logic signed [DIFF_W-1:0]   w_diff  [2];
    logic signed [MUL_W-1:0]    w_step  [2];
    logic signed [SUM_W-1:0]    w_sum   [2];
    logic signed [PHASE_W:0]    w_p;

    logic signed [MUL_W-1:0]    r_prod  [2];
    logic [POS_BITS-1:0]        r_pos   [2][2:NSTAGE-1];

    always_comb begin
        w_start[0] = i_cfg.start_x;
        w_start[1] = i_cfg.start_y;
        w_diff[0]  = DIFF_W'(i_cfg.end_x) - DIFF_W'(i_cfg.start_x);
        w_diff[1]  = DIFF_W'(i_cfg.end_y) - DIFF_W'(i_cfg.start_y);
        w_p        = $signed({1'b0, i_p});
        for (int a = 0; a < 2; a++) begin
            w_step[a] = (r_prod[a] + RND_HALF) >>> PHASE_FRAC_BITS;
            w_sum[a]  = SUM_W'(w_start[a]) + SUM_W'(w_step[a]);
        end
    end

    always_ff @(posedge i_clk) begin
        for (int a = 0; a < 2; a++) begin
            if (i_en[0]) begin
                r_prod[a] <= w_diff[a] * w_p;
            end
            if (i_en[1]) begin
                r_pos[a][2] <= sat_pos(w_sum[a]);
            end
            for (int s = 3; s < NSTAGE; s++) begin
                if (i_en[s-1]) begin
                    r_pos[a][s] <= r_pos[a][s-1];
                end
            end
        end
    end

    assign o_pos_x = r_pos[0][NSTAGE-1];
    assign o_pos_y = r_pos[1][NSTAGE-1];

endmodule

>>> design/cfst_z.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfst_z
// Stages 4 and 5: lift and slope products, Z sum and saturation.
// ----------------------------------------------------------------------------
module cfst_z (
    input  logic                            i_clk,
    input  logic [1:0]                      i_en,
    input  cfst_pkg::t_cfg                  i_cfg,
    input  cfst_pkg::t_cyc                  i_cyc,
    output logic [cfst_pkg::POS_BITS-1:0]   o_pos_z
);
    import cfst_pkg::*;

    localparam int HP_W = LIFT_BITS + 1 + CYC_W;
    localparam int DP_W = DIFF_W + PHASE_W + 1;
    localparam logic signed [HP_W-1:0]  H_HALF = HP_W'(1) << (PHASE_FRAC_BITS - 1);
    localparam logic signed [DP_W-1:0]  D_HALF = DP_W'(1) << (PHASE_FRAC_BITS - 1);
    localparam logic signed [CYC_W-1:0] ONE_C  = $signed({2'b00, PHASE_ONE});

    logic signed [CYC_W-1:0]  w_hop;
    logic signed [DIFF_W-1:0] w_dz;
    logic signed [HP_W-1:0]   w_ht;
    logic signed [DP_W-1:0]   w_dt;
    logic signed [SUM_W-1:0]  w_z;

    logic signed [HP_W-1:0]   r_hprod;
    logic signed [DP_W-1:0]   r_dzprod;
    logic                     r_first;
    logic [POS_BITS-1:0]      r_pos_z;

    // stage 4: rising half uses c(u), falling half uses 1 - c(u)
    always_comb begin
        w_hop = i_cyc.first ? i_cyc.cyc : (ONE_C - i_cyc.cyc);
        w_dz  = DIFF_W'(i_cfg.end_z) - DIFF_W'(i_cfg.start_z);
    end

    // stage 5
    always_comb begin
        w_ht = (r_hprod + H_HALF) >>> PHASE_FRAC_BITS;
        w_dt = (r_dzprod + D_HALF) >>> PHASE_FRAC_BITS;
        w_z  = SUM_W'(i_cfg.start_z) + SUM_W'(w_ht);
        if (!r_first) begin
            w_z = w_z + SUM_W'(w_dt);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_hprod  <= $signed({1'b0, i_cfg.lift_height}) * w_hop;
            r_dzprod <= w_dz * $signed({1'b0, i_cyc.u});
            r_first  <= i_cyc.first;
        end
        if (i_en[1]) begin
            r_pos_z  <= sat_pos(w_z);
        end
    end

    assign o_pos_z = r_pos_z;

endmodule

>>> design/cfst_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfst_checker
// Port-level checks of the trajectory pipeline, bound to the top level.
// ----------------------------------------------------------------------------
module cfst_checker (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               o_s_axis_tready,
    input  logic [3*cfst_pkg::POS_BITS-1:0]    o_m_axis_tdata,
    input  logic                               o_m_axis_tvalid,
    input  logic                               i_m_axis_tready
);

    // a stalled result keeps its transaction
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !i_m_axis_tready)
            |=> (o_m_axis_tvalid && $stable(o_m_axis_tdata)))
        else $error("output transaction changed while stalled");

    // an empty output stage means nothing upstream can be blocked
    a_empty_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_m_axis_tvalid |-> o_s_axis_tready)
        else $error("input stalled with empty output stage");

    // downstream ready propagates to the input the same cycle
    a_ready_pass: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_axis_tready |-> o_s_axis_tready)
        else $error("input stalled while output is ready");

    // reset empties the pipeline
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("output valid after reset");

endmodule

bind cycloid_foot_swing_trajectory cfst_checker u_cfst_checker (.*);

>>> tb/sv/tb_cycloid_foot_swing_trajectory.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_cycloid_foot_swing_trajectory
// Streams swing phases through the foot trajectory pipeline under random
// source gaps and sink stalls. A bit-accurate predictor of the linear X/Y path
// and the two-half cycloid Z lift checks every output transaction in order.
// Register settings change between runs, once the pipeline has drained.
// ----------------------------------------------------------------------------
module tb_cycloid_foot_swing_trajectory;

    localparam int FRAC      = cfst_pkg::PHASE_FRAC_BITS;
    localparam int DEPTH     = cfst_pkg::SINE_TABLE_DEPTH;
    localparam int PW        = cfst_pkg::POS_BITS;
    localparam int IDX_W     = cfst_pkg::CFG_IDX_W;
    localparam longint ONE   = longint'(1) << FRAC;
    localparam logic [23:0] POS_MIN = 24'h800000;
    localparam logic [23:0] POS_MAX = 24'h7FFFFF;
    // the one index of the 3-bit map that holds no register
    localparam logic [IDX_W-1:0] CFG_IDX_UNUSED = 3'd7;
    localparam int N_SETTINGS  = 20;
    localparam int ITEMS_EACH  = 50;
    localparam longint TIMEOUT_NS = 64'd8_000_000;

    typedef struct packed {
        logic signed [PW-1:0] z;
        logic signed [PW-1:0] y;
        logic signed [PW-1:0] x;
    } t_foot;

    // ------------------------------------------------------------------------
    // scoreboard: register shadow, sine table, foot position predictor
    // ------------------------------------------------------------------------
    class swing_scoreboard;
        longint start_x, start_y, start_z, end_x, end_y, end_z, lift;
        longint qsine [0:DEPTH];
        t_foot  expected_feet [$];
        int     n_err;
        int     n_phases;
        int     n_checked;

        function new();
            longint unsigned x, x2, term;
            longint          acc, v;
            start_x = 0; start_y = 0; start_z = 0;
            end_x = 0; end_y = 0; end_z = 0; lift = 0;
            n_err = 0; n_phases = 0; n_checked = 0;
            // quarter-wave sine in Q16, Taylor series evaluated in Q30
            for (int i = 0; i <= DEPTH; i++) begin
                x    = longint'(cfst_pkg::PI_HALF_Q30) * i / DEPTH;
                x2   = (x * x) >> 30;
                term = x;
                acc  = longint'(x);
                for (int n = 1; n <= 8; n++) begin
                    term = ((term * x2) >> 30) / longint'((2 * n) * (2 * n + 1));
                    if (n % 2 == 1) begin
                        acc = acc - longint'(term);
                    end else begin
                        acc = acc + longint'(term);
                    end
                end
                v = rnd(acc, 14);
                if (v < 0) v = 0;
                if (v > 65536) v = 65536;
                qsine[i] = v;
            end
        endfunction

        static function longint rnd(longint v, int s);
            return (v + (longint'(1) << (s - 1))) >>> s;
        endfunction

        static function logic [PW-1:0] clamp_pos(longint v);
            longint hi;
            longint lo;
            hi = (longint'(1) << (PW - 1)) - 1;
            lo = -(longint'(1) << (PW - 1));
            if (v > hi) v = hi;
            if (v < lo) v = lo;
            return v[PW-1:0];
        endfunction

        function void write_reg(logic [IDX_W-1:0] idx, logic [PW-1:0] data);
            case (idx)
                cfst_pkg::REG_START_X:     start_x = longint'($signed(data));
                cfst_pkg::REG_START_Y:     start_y = longint'($signed(data));
                cfst_pkg::REG_START_Z:     start_z = longint'($signed(data));
                cfst_pkg::REG_END_X:       end_x   = longint'($signed(data));
                cfst_pkg::REG_END_Y:       end_y   = longint'($signed(data));
                cfst_pkg::REG_END_Z:       end_z   = longint'($signed(data));
                cfst_pkg::REG_LIFT_HEIGHT: lift    = longint'(data[cfst_pkg::LIFT_BITS-1:0]);
                default: ;  // unmapped index, dropped
            endcase
        endfunction

        // sine of a full turn times u, Q16
        function longint sine_of_turn(longint u);
            longint k, q, r;
            k = rnd(u * 4 * DEPTH, FRAC) % (4 * DEPTH);
            q = k / DEPTH;
            r = k % DEPTH;
            case (q)
                0:       return qsine[r];
                1:       return qsine[DEPTH - r];
                2:       return -qsine[r];
                default: return -qsine[DEPTH - r];
            endcase
        endfunction

        function t_foot foot_at(logic [FRAC:0] phase);
            longint p, u, cyc, z;
            bit     first;
            t_foot  f;
            p = (longint'(phase) > ONE) ? ONE : longint'(phase);
            f.x = clamp_pos(start_x + rnd((end_x - start_x) * p, FRAC));
            f.y = clamp_pos(start_y + rnd((end_y - start_y) * p, FRAC));
            // midpoint falls in the second half with u = 0
            first = (2 * p) < ONE;
            u   = first ? 2 * p : 2 * p - ONE;
            cyc = u - rnd(sine_of_turn(u) * cfst_pkg::INV_2PI_Q32, 48 - FRAC);
            if (first) begin
                z = start_z + rnd(lift * cyc, FRAC);
            end else begin
                z = start_z + rnd((end_z - start_z) * u, FRAC) + rnd(lift * (ONE - cyc), FRAC);
            end
            f.z = clamp_pos(z);
            return f;
        endfunction

        function void note_phase(logic [FRAC:0] phase);
            expected_feet.push_back(foot_at(phase));
            n_phases++;
        endfunction

        task report(string msg);
            $display("mismatch: %s", msg);
            n_err++;
        endtask

        task check_foot(logic [3*PW-1:0] data);
            t_foot got;
            t_foot want;
            got = data;
            if (expected_feet.size() == 0) begin
                report($sformatf("output x=%0d y=%0d z=%0d with nothing expected",
                                 got.x, got.y, got.z));
            end else begin
                want = expected_feet.pop_front();
                n_checked++;
                if (got.x !== want.x)
                    report($sformatf("pos_x got %0d want %0d", got.x, want.x));
                if (got.y !== want.y)
                    report($sformatf("pos_y got %0d want %0d", got.y, want.y));
                if (got.z !== want.z)
                    report($sformatf("pos_z got %0d want %0d", got.z, want.z));
            end
        endtask

        function int pending();
            return expected_feet.size();
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // dut signals, all inputs known from time zero
    // ------------------------------------------------------------------------
    logic              i_clk           = 1'b0;
    logic              i_rst_n         = 1'b0;
    logic [23:0]       i_s_axis_tdata  = '0;   // phase [16:0], zero fill [23:17]
    logic              i_s_axis_tvalid = 1'b0;
    logic              o_s_axis_tready;
    logic [3*PW-1:0]   o_m_axis_tdata;         // pos_x [23:0], pos_y [47:24], pos_z [71:48]
    logic              o_m_axis_tvalid;
    logic              i_m_axis_tready = 1'b0;
    logic              i_cfg_valid     = 1'b0;
    logic              o_cfg_ready;
    logic [IDX_W-1:0]  i_cfg_index     = '0;
    logic [PW-1:0]     i_cfg_data      = '0;

    swing_scoreboard sb = new();
    int  n_settings = 0;
    bit  src_burst  = 1'b0;   // source stretch with no gaps
    bit  sink_burst = 1'b0;   // sink stretch with no stalls

    cycloid_foot_swing_trajectory dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    // 20 ns clock
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 0;
    end

    // ------------------------------------------------------------------------
    // monitors: every handshake is sampled at the rising edge, before the
    // nonblocking updates of that edge land
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_cfg_valid && o_cfg_ready) begin
            sb.write_reg(i_cfg_index, i_cfg_data);
        end
        if (i_s_axis_tvalid && o_s_axis_tready) begin
            sb.note_phase(i_s_axis_tdata[FRAC:0]);
        end
        if (o_m_axis_tvalid && i_m_axis_tready) begin
            sb.check_foot(o_m_axis_tdata);
        end
    end

    // sink: random stall before each output transaction,
    // with occasional stretches of full throughput
    initial begin
        int stall;
        @(posedge i_rst_n);
        forever begin
            if ($urandom_range(0, 31) == 0) sink_burst = !sink_burst;
            stall = sink_burst ? 0 : $urandom_range(0, 8);
            if (stall > 0) begin
                i_m_axis_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_m_axis_tready <= 1'b1;
            @(posedge i_clk);
            while (!o_m_axis_tvalid) @(posedge i_clk);
        end
    end

    // ------------------------------------------------------------------------
    // drivers
    // ------------------------------------------------------------------------
    // leaves valid high after the write so back-to-back writes need no toggle
    task automatic write_reg(logic [IDX_W-1:0] idx, logic [PW-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
    endtask

    task automatic end_writes();
        i_cfg_valid <= 1'b0;
        n_settings++;
    endtask

    // one phase transaction after a random gap; valid stays high when no gap
    task automatic send_phase(logic [FRAC:0] phase);
        int gap;
        if ($urandom_range(0, 31) == 0) src_burst = !src_burst;
        gap = src_burst ? 0 : $urandom_range(0, 8);
        if (gap > 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {{(24 - FRAC - 1){1'b0}}, phase};
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
    endtask

    // drop valid, wait out every expected result, then let the pipeline idle
    task automatic drain();
        i_s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (cfst_pkg::NSTAGE + 2) @(posedge i_clk);
    endtask

    function automatic logic [PW-1:0] pick_pos();
        case ($urandom_range(0, 5))
            0:       return POS_MIN;
            1:       return POS_MAX;
            2:       return '0;
            3:       return PW'($signed($urandom_range(0, 20000)) - 10000);
            default: return PW'($urandom);
        endcase
    endfunction

    function automatic logic [PW-1:0] pick_lift();
        case ($urandom_range(0, 4))
            0:       return '0;
            1:       return PW'((1 << cfst_pkg::LIFT_BITS) - 1);
            2:       return PW'($urandom_range(0, 5000));
            default: return PW'($urandom);   // upper bits above the lift field too
        endcase
    endfunction

    // mostly in range, some landmarks, some above one
    function automatic logic [FRAC:0] pick_phase();
        logic [FRAC:0] marks [11] = '{0, 1, 63, 64, 16384, 32767, 32768, 32769,
                                      49152, 65535, 65536};
        case ($urandom_range(0, 9))
            0:       return marks[$urandom_range(0, 10)];
            1:       return (FRAC + 1)'($urandom_range(65537, 131071));
            default: return (FRAC + 1)'($urandom_range(0, 65536));
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------------
    initial begin
        logic [FRAC:0] first_pass [13] = '{0, 1, 256, 8192, 16384, 32767, 32768,
                                           32769, 49152, 65535, 65536, 65537, 131071};
        logic [FRAC:0] second_pass [5] = '{0, 16384, 32768, 40000, 65536};

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // registers still at reset: everything sits at the origin
        send_phase(0);
        send_phase(32768);
        send_phase(65536);
        drain();

        // widest swing, opposite X and Y, full lift: Z climbs to the positive limit at the end
        write_reg(cfst_pkg::REG_START_X, POS_MIN);
        write_reg(cfst_pkg::REG_END_X, POS_MAX);
        write_reg(cfst_pkg::REG_START_Y, POS_MAX);
        write_reg(cfst_pkg::REG_END_Y, POS_MIN);
        write_reg(cfst_pkg::REG_START_Z, POS_MIN);
        write_reg(cfst_pkg::REG_END_Z, POS_MAX);
        write_reg(cfst_pkg::REG_LIFT_HEIGHT, 24'hFFFFFF);
        write_reg(CFG_IDX_UNUSED, 24'h123456);   // must not disturb anything
        end_writes();
        foreach (first_pass[i]) send_phase(first_pass[i]);
        drain();

        // start high, end low: lift pushes Z past the positive limit
        write_reg(cfst_pkg::REG_START_Z, POS_MAX);
        write_reg(cfst_pkg::REG_END_Z, POS_MIN);
        write_reg(cfst_pkg::REG_START_X, 24'd0);
        write_reg(CFG_IDX_UNUSED, POS_MIN);
        end_writes();
        foreach (second_pass[i]) send_phase(second_pass[i]);
        drain();

        // random settings, each followed by a run of random phases
        for (int s = 0; s < N_SETTINGS; s++) begin
            for (int r = 0; r < int'(cfst_pkg::REG_LIFT_HEIGHT); r++) begin
                write_reg(IDX_W'(r), pick_pos());
            end
            write_reg(cfst_pkg::REG_LIFT_HEIGHT, pick_lift());
            if ($urandom_range(0, 3) == 0) write_reg(CFG_IDX_UNUSED, PW'($urandom));
            end_writes();
            for (int n = 0; n < ITEMS_EACH; n++) send_phase(pick_phase());
            drain();
        end

        repeat (2 * cfst_pkg::NSTAGE + 4) @(posedge i_clk);
        if (sb.pending() != 0) begin
            sb.report($sformatf("%0d results never arrived", sb.pending()));
        end
        $display("covered %0d phase transactions under %0d register settings",
                 sb.n_phases, n_settings);
        $display("%0d output transactions checked, %0d mismatches",
                 sb.n_checked, sb.n_err);
        if (sb.n_err == 0) begin
            $display("tb_cycloid_foot_swing_trajectory: PASS");
        end else begin
            $display("tb_cycloid_foot_swing_trajectory: FAIL");
        end
        $finish;
    end

    // watchdog, far above the slowest legal run
    initial begin
        #(TIMEOUT_NS);
        $display("timeout with %0d results outstanding", sb.pending());
        $display("tb_cycloid_foot_swing_trajectory: FAIL");
        $finish;
    end

endmodule
